[rtl/crcx_pkg.sv]
// ----------------------------------------------------------------------------
// CRC-16/XMODEM frame appender package
// Shared types, constants and the byte-wide CRC update.
// ----------------------------------------------------------------------------
`default_nettype none

package crcx_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CRC_W       = 16;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [CRC_W-1:0]  crc;
   } entry_type;

   typedef enum logic [1:0] {
      PHASE_DATA,
      PHASE_CRC_LO,
      PHASE_CRC_HI
   } phase_type;

   function automatic logic [CRC_W-1:0] crc_add_byte(
      input logic [CRC_W-1:0]  crc,
      input logic [BYTE_W-1:0] b
   );
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/crcx_front.sv]
// ----------------------------------------------------------------------------
// CRC-16/XMODEM frame appender front end
// Accepts payload bytes, updates the running CRC and queues each byte with
// its last flag and the CRC that includes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crcx_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [7:0]                  req_payload_byte,
   input  wire logic                        req_payload_last,
   input  wire logic                        queue_full,
   output logic                             push_valid,
   output crcx_pkg::entry_type              push_entry
);
   import crcx_pkg::*;

   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;
   logic [CRC_W-1:0] crc_next;
   logic             accept;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign crc_next   = crc_add_byte(crc_ff, req_payload_byte);
   assign push_valid = accept;

   always_comb begin
      push_entry.data = req_payload_byte;
      push_entry.last = req_payload_last;
      push_entry.crc  = crc_next;
      crc_in          = crc_ff;
      if (accept) begin
         crc_in = req_payload_last ? '0 : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

`default_nettype wire

[rtl/crcx_queue.sv]
// ----------------------------------------------------------------------------
// CRC-16/XMODEM frame appender queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module crcx_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire crcx_pkg::entry_type  push_entry,
   output logic                      queue_full,
   output logic                      queue_empty,
   input  wire logic                 pop,
   output crcx_pkg::entry_type       head_entry
);
   import crcx_pkg::*;

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   assign queue_full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign do_push     = push_valid && !queue_full;
   assign do_pop      = pop && !queue_empty;
   assign head_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/crcx_back.sv]
// ----------------------------------------------------------------------------
// CRC-16/XMODEM frame appender back end
// Drains the queue into the output register and appends the CRC low and
// high bytes after the last payload byte of each message.
// ----------------------------------------------------------------------------
`default_nettype none

module crcx_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 queue_empty,
   input  wire crcx_pkg::entry_type  head_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_tx_byte,
   output logic                      rsp_frame_end
);
   import crcx_pkg::*;

   phase_type         phase_ff;
   phase_type         phase_in;
   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic              end_ff;
   logic              end_in;
   logic              load;

   assign load          = !valid_ff || !rsp_stall;
   assign rsp_valid     = valid_ff;
   assign rsp_tx_byte   = byte_ff;
   assign rsp_frame_end = end_ff;

   always_comb begin
      phase_in = phase_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b0;
         case (phase_ff)
            PHASE_DATA: begin
               if (!queue_empty) begin
                  valid_in = 1'b1;
                  byte_in  = head_entry.data;
                  end_in   = 1'b0;
                  if (head_entry.last) begin
                     phase_in = PHASE_CRC_LO;
                  end else begin
                     pop = 1'b1;
                  end
               end
            end
            PHASE_CRC_LO: begin
               valid_in = 1'b1;
               byte_in  = head_entry.crc[BYTE_W-1:0];
               end_in   = 1'b0;
               phase_in = PHASE_CRC_HI;
            end
            PHASE_CRC_HI: begin
               valid_in = 1'b1;
               byte_in  = head_entry.crc[CRC_W-1:BYTE_W];
               end_in   = 1'b1;
               pop      = 1'b1;
               phase_in = PHASE_DATA;
            end
            default: begin
               phase_in = PHASE_DATA;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_DATA;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

endmodule

`default_nettype wire

[rtl/crc16_xmodem_frame_appender_unit.sv]
// ----------------------------------------------------------------------------
// CRC-16/XMODEM frame appender
// Passes payload bytes through and appends the CRC-16/XMODEM low and high
// bytes after the last byte of each message.
// ----------------------------------------------------------------------------
// The block passes each payload byte through unchanged and follows the byte
// flagged as last with the CRC-16/XMODEM of the message (polynomial 0x1021,
// initial value zero, MSB first, no final XOR), low byte first, with
// rsp_frame_end set on the high byte; the CRC then restarts at zero. The
// front end takes one byte per cycle while its four-entry queue has room,
// and the output register delivers one result per cycle while rsp_stall is
// low, so an ordinary byte yields one result and a last byte three results
// on the output port. A byte is written into a queue slot when it is
// accepted and passes from there into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_xmodem_frame_appender_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_payload_byte,
   input  wire logic       req_payload_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_frame_end
);
   import crcx_pkg::*;

   logic      queue_full;
   logic      queue_empty;
   logic      push_valid;
   entry_type push_entry;
   entry_type head_entry;
   logic      pop;

   crcx_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_payload_last (req_payload_last),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   crcx_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_entry  (push_entry),
      .queue_full  (queue_full),
      .queue_empty (queue_empty),
      .pop         (pop),
      .head_entry  (head_entry)
   );

   crcx_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

[rtl/crcx_checker.sv]
// ----------------------------------------------------------------------------
// CRC-16/XMODEM frame appender checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crcx_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_tx_byte,
   input wire logic       rsp_frame_end
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("Outputs not idle after reset.");

   a_no_back_to_back_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_frame_end |=> !(rsp_valid && rsp_frame_end))
      else $error("Two frame ends without a CRC low byte between them.");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result dropped while stalled.");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_tx_byte) && $stable(rsp_frame_end))
      else $error("Result changed while stalled.");

endmodule

bind crc16_xmodem_frame_appender_unit crcx_checker u_checker (.*);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16/XMODEM frame appender testbench
// Sends directed and random messages through the block, predicts the
// pass-through bytes and the appended CRC trailer of every message, and
// compares each received transaction against the oldest expected byte.
// Both sides pause at random, and the receiver holds off long enough for
// the block to fill up and stall its input.
// ----------------------------------------------------------------------------

module testbench;

   import crcx_pkg::*;

   localparam int CYCLE_LIMIT    = 100000;
   localparam int DIRECTED_COUNT = 23;
   localparam int RANDOM_COUNT   = 345;
   localparam int LONG_HOLD      = 80;
   localparam int DRAIN_CYCLES   = 10;

   typedef struct {
      logic [BYTE_W-1:0] tx_byte;
      logic              frame_end;
   } tx_beat_type;

   class crc_frame_scoreboard;
      localparam logic [CRC_W-1:0] XMODEM_POLY = 16'h1021;

      logic [CRC_W-1:0] message_crc;
      tx_beat_type      expected_tx[$];
      int               error_count;

      function new();
         message_crc = '0;
         error_count = 0;
      endfunction

      function logic [CRC_W-1:0] fold_byte(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
         logic feedback;
         for (int i = BYTE_W - 1; i >= 0; i--) begin
            feedback = crc[CRC_W-1] ^ b[i];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (feedback) begin
               crc = crc ^ XMODEM_POLY;
            end
         end
         return crc;
      endfunction

      function void note_payload(logic [BYTE_W-1:0] b, logic last);
         tx_beat_type beat;
         message_crc = fold_byte(message_crc, b);
         beat.tx_byte   = b;
         beat.frame_end = 1'b0;
         expected_tx.push_back(beat);
         if (last) begin
            beat.tx_byte   = message_crc[7:0];
            beat.frame_end = 1'b0;
            expected_tx.push_back(beat);
            beat.tx_byte   = message_crc[15:8];
            beat.frame_end = 1'b1;
            expected_tx.push_back(beat);
            message_crc = '0;
         end
      endfunction

      function void check_tx(logic [BYTE_W-1:0] tx_byte, logic frame_end);
         tx_beat_type beat;
         if (expected_tx.size() == 0) begin
            $error("Unexpected transaction: tx_byte %02h, frame_end %0b", tx_byte, frame_end);
            error_count++;
            return;
         end
         beat = expected_tx.pop_front();
         if (tx_byte !== beat.tx_byte) begin
            $error("tx_byte: expected %02h, actual %02h", beat.tx_byte, tx_byte);
            error_count++;
         end
         if (frame_end !== beat.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", beat.frame_end, frame_end);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_tx.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [BYTE_W-1:0] req_payload_byte;
   logic              req_payload_last;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [BYTE_W-1:0] rsp_tx_byte;
   logic              rsp_frame_end;

   crc_frame_scoreboard frame_ledger = new();
   int                  cycle_count = 0;
   int                  bytes_sent = 0;
   bit                  idle_on = 1'b1;
   bit                  long_hold_armed = 1'b0;

   crc16_xmodem_frame_appender_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_payload_last (req_payload_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            frame_ledger.note_payload(req_payload_byte, req_payload_last);
         end
         if (rsp_valid && !rsp_stall) begin
            frame_ledger.check_tx(rsp_tx_byte, rsp_frame_end);
         end
      end
   end

   task automatic send_payload(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= b;
      req_payload_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_message(input logic [BYTE_W-1:0] body[$]);
      for (int i = 0; i < body.size(); i++) begin
         send_payload(body[i], i == body.size() - 1);
      end
   endtask

   initial begin
      int wait_cycles;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = idle_on ? $urandom_range(0, 4) : 0;
         if (long_hold_armed) begin
            wait_cycles = LONG_HOLD;
            long_hold_armed = 1'b0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic [BYTE_W-1:0] body[$];
      int                message_len;
      bit                second_hold_done;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_payload_byte <= '0;
      req_payload_last <= 1'b0;
      second_hold_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      body = '{8'h00};
      send_message(body);
      body = '{8'hFF};
      send_message(body);
      body = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h7F, 8'hFE};
      send_message(body);
      body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_message(body);
      body = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
      send_message(body);

      long_hold_armed = 1'b1;
      while (bytes_sent < DIRECTED_COUNT + RANDOM_COUNT) begin
         idle_on = ((bytes_sent / 60) % 3) != 2;
         if (!second_hold_done && bytes_sent > DIRECTED_COUNT + RANDOM_COUNT / 2) begin
            long_hold_armed = 1'b1;
            second_hold_done = 1'b1;
         end
         message_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 8);
         body.delete();
         for (int i = 0; i < message_len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               body.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
            end else begin
               body.push_back(BYTE_W'($urandom_range(0, 255)));
            end
         end
         send_message(body);
      end
      req_valid <= 1'b0;

      while (frame_ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frame_ledger.error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
